### rtl/core/svp_pkg.sv
// ----------------------------------------------------------------------------
// S-curve velocity profiler package
// Shared widths, codes, payload types and the velocity saturation function.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int VEL_W  = 32;
    localparam int TICK_W = 24;
    localparam int CNT_W  = TICK_W + 4;
    localparam int DT_W   = CNT_W + 2;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [1:0] POL_WAIT = 2'd0;
    localparam logic [1:0] POL_NOW  = 2'd1;
    localparam logic [1:0] POL_EXT  = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_JERK_UP  = 3'd1;
    localparam logic [2:0] PH_ACCEL    = 3'd2;
    localparam logic [2:0] PH_JERK_DN  = 3'd3;
    localparam logic [2:0] PH_CRUISE   = 3'd4;
    localparam logic [2:0] PH_DJERK_UP = 3'd5;
    localparam logic [2:0] PH_DECEL    = 3'd6;
    localparam logic [2:0] PH_DJERK_DN = 3'd7;

    localparam logic [IDX_W-1:0] REG_ACCEL_JERK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DECEL_JERK   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL_JTICKS = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACCEL_CTICKS = 3'd3;
    localparam logic [IDX_W-1:0] REG_CRUISE_TICKS = 3'd4;
    localparam logic [IDX_W-1:0] REG_DECEL_JTICKS = 3'd5;
    localparam logic [IDX_W-1:0] REG_DECEL_CTICKS = 3'd6;

    localparam logic signed [63:0] V_MAX64 = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
    localparam logic signed [63:0] V_MIN64 = -V_MAX64 - 64'sd1;
    localparam logic [63:0]        PROD_LIM = 64'd1 << 62;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VEL_W-1:0] start_velocity;
        logic signed [VEL_W-1:0] end_velocity;
        logic                    follow_mode;
        logic [1:0]              start_policy;
        logic                    start_allowed;
        logic signed [VEL_W-1:0] host_velocity;
    } item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic [2:0]              phase;
        logic                    buffer_empty;
    } result_t;

    typedef struct packed {
        logic signed [31:0] accel_jerk;
        logic signed [31:0] decel_jerk;
        logic [TICK_W-1:0]  accel_jerk_ticks;
        logic [TICK_W-1:0]  accel_const_ticks;
        logic [TICK_W-1:0]  cruise_ticks;
        logic [TICK_W-1:0]  decel_jerk_ticks;
        logic [TICK_W-1:0]  decel_const_ticks;
    } cfg_t;

    typedef struct packed {
        logic       commit;
        logic       follow_load;
        logic       init;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       apply;
        logic       inc_elapsed;
        logic       load_out;
        logic [2:0] phase;
        logic       buffer_empty;
    } cmd_t;

    typedef struct packed {
        logic crossing;
    } status_t;

    function automatic logic signed [VEL_W-1:0] sat_v(input logic signed [63:0] x);
        logic signed [63:0] r;
        begin
            if (x > V_MAX64)
            begin
                r = V_MAX64;
            end
            else if (x < V_MIN64)
            begin
                r = V_MIN64;
            end
            else
            begin
                r = x;
            end
            return r[VEL_W-1:0];
        end
    endfunction

endpackage

### rtl/core/svp_regs.sv
// ----------------------------------------------------------------------------
// S-curve profiler configuration registers
// APB-style register file holding jerk values and phase lengths.
// ----------------------------------------------------------------------------
module svp_regs
    import svp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ACCEL_JERK:   cfg_reg.accel_jerk        <= pwdata;
                REG_DECEL_JERK:   cfg_reg.decel_jerk        <= pwdata;
                REG_ACCEL_JTICKS: cfg_reg.accel_jerk_ticks  <= pwdata[TICK_W-1:0];
                REG_ACCEL_CTICKS: cfg_reg.accel_const_ticks <= pwdata[TICK_W-1:0];
                REG_CRUISE_TICKS: cfg_reg.cruise_ticks      <= pwdata[TICK_W-1:0];
                REG_DECEL_JTICKS: cfg_reg.decel_jerk_ticks  <= pwdata[TICK_W-1:0];
                REG_DECEL_CTICKS: cfg_reg.decel_const_ticks <= pwdata[TICK_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ACCEL_JERK:   prdata = cfg_reg.accel_jerk;
            REG_DECEL_JERK:   prdata = cfg_reg.decel_jerk;
            REG_ACCEL_JTICKS: prdata = 32'(cfg_reg.accel_jerk_ticks);
            REG_ACCEL_CTICKS: prdata = 32'(cfg_reg.accel_const_ticks);
            REG_CRUISE_TICKS: prdata = 32'(cfg_reg.cruise_ticks);
            REG_DECEL_JTICKS: prdata = 32'(cfg_reg.decel_jerk_ticks);
            REG_DECEL_CTICKS: prdata = 32'(cfg_reg.decel_const_ticks);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/svp_ctrl.sv
// ----------------------------------------------------------------------------
// S-curve profiler controller
// Sequences ops, the staging buffer and the per-phase multiply steps.
// ----------------------------------------------------------------------------
module svp_ctrl
    import svp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_MUL3  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       following_reg, following_next;
    logic       locked_reg, locked_next;
    logic       pending_reg, pending_next;
    logic       pend_follow_reg, pend_follow_next;
    logic [1:0] pend_policy_reg, pend_policy_next;
    logic       out_valid_reg, out_valid_next;
    logic       allow;
    logic       start;
    logic       follow_now;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    assign allow = (pend_policy_reg == POL_NOW) ||
                   ((pend_policy_reg == POL_EXT) && item.start_allowed);
    assign start = !locked_reg && pending_reg && allow;
    assign follow_now = start ? pend_follow_reg
                              : (following_reg && (phase_reg == PH_IDLE));

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        following_next   = following_reg;
        locked_next      = locked_reg;
        pending_next     = pending_reg;
        pend_follow_next = pend_follow_reg;
        pend_policy_next = pend_policy_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        cmd.phase        = phase_reg;
        cmd.buffer_empty = !pending_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DONE;
                    case (item.op)
                        OP_LOCK:
                        begin
                            locked_next = 1'b1;
                        end
                        OP_COMMIT:
                        begin
                            cmd.commit       = 1'b1;
                            pend_follow_next = item.follow_mode;
                            pend_policy_next = item.start_policy;
                            pending_next     = 1'b1;
                            locked_next      = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (start)
                            begin
                                pending_next   = 1'b0;
                                following_next = pend_follow_reg;
                                phase_next     = PH_IDLE;
                            end
                            if (follow_now)
                            begin
                                cmd.follow_load = 1'b1;
                            end
                            else if (start)
                            begin
                                cmd.init   = 1'b1;
                                phase_next = PH_JERK_UP;
                                state_next = S_MUL1;
                            end
                            else if (phase_reg != PH_IDLE)
                            begin
                                state_next = S_MUL1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (!status.crossing)
                begin
                    cmd.inc_elapsed = 1'b1;
                    state_next      = S_DONE;
                end
                else if (phase_reg == PH_DJERK_DN)
                begin
                    cmd.inc_elapsed = 1'b1;
                    phase_next      = PH_IDLE;
                    state_next      = S_DONE;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                    state_next = S_MUL1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_IDLE;
            following_reg   <= 1'b0;
            locked_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            pend_follow_reg <= 1'b0;
            pend_policy_reg <= POL_WAIT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            following_reg   <= following_next;
            locked_reg      <= locked_next;
            pending_reg     <= pending_next;
            pend_follow_reg <= pend_follow_next;
            pend_policy_reg <= pend_policy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

### rtl/core/svp_dp.sv
// ----------------------------------------------------------------------------
// S-curve profiler datapath
// Tick counters, velocity state and one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module svp_dp
    import svp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  cmd_t    cmd,
    output status_t status,
    output result_t result
);

    logic [CNT_W-1:0]        elapsed_reg, seg_reg, bnd_reg;
    logic signed [VEL_W-1:0] base_v_reg, base_a_reg, cur_v_reg, end_v_reg;
    logic signed [VEL_W-1:0] pend_start_reg, pend_end_reg;
    logic [63:0]             p1_mag_reg, p2_mag_reg;
    logic                    p1_neg_reg, b_neg_reg;
    logic [31:0]             b_mag_reg;
    result_t                 result_reg;

    logic                    crossing;
    logic signed [DT_W-1:0]  dt, t_cur_s, a_op, b_op;
    logic [TICK_W-1:0]       t_cur, t_nxt;
    logic signed [31:0]      j_op;
    logic                    use_j;
    logic [31:0]             j_mag, a_mag, b_mag, mul_x, mul_y;
    logic [63:0]             mprod;
    logic [64:0]             total;
    logic                    ovf;
    logic signed [63:0]      p1_s, p2_s, term, sum, ba_sum;

    assign crossing = (elapsed_reg >= bnd_reg);
    assign status.crossing = crossing;
    assign result  = result_reg;
    assign dt      = $signed({2'b00, elapsed_reg}) - $signed({2'b00, seg_reg});
    assign t_cur_s = $signed({{(DT_W-TICK_W){1'b0}}, t_cur});

    always_comb
    begin
        case (cmd.phase)
            PH_JERK_UP:  begin t_cur = cfg.accel_jerk_ticks;  t_nxt = cfg.accel_const_ticks; end
            PH_ACCEL:    begin t_cur = cfg.accel_const_ticks; t_nxt = cfg.accel_jerk_ticks;  end
            PH_JERK_DN:  begin t_cur = cfg.accel_jerk_ticks;  t_nxt = cfg.cruise_ticks;      end
            PH_CRUISE:   begin t_cur = cfg.cruise_ticks;      t_nxt = cfg.decel_jerk_ticks;  end
            PH_DJERK_UP: begin t_cur = cfg.decel_jerk_ticks;  t_nxt = cfg.decel_const_ticks; end
            PH_DECEL:    begin t_cur = cfg.decel_const_ticks; t_nxt = cfg.decel_jerk_ticks;  end
            PH_DJERK_DN: begin t_cur = cfg.decel_jerk_ticks;  t_nxt = '0;                    end
            default:     begin t_cur = '0;                    t_nxt = '0;                    end
        endcase
    end

    always_comb
    begin
        case (cmd.phase)
            PH_JERK_UP, PH_JERK_DN:   begin j_op = cfg.accel_jerk; use_j = 1'b1; end
            PH_DJERK_UP, PH_DJERK_DN: begin j_op = cfg.decel_jerk; use_j = 1'b1; end
            default:                  begin j_op = base_a_reg;     use_j = 1'b0; end
        endcase
        if (crossing)
        begin
            a_op = t_cur_s;
        end
        else if ((cmd.phase == PH_JERK_DN) || (cmd.phase == PH_DJERK_DN))
        begin
            a_op = (t_cur_s <<< 1) - dt;
        end
        else
        begin
            a_op = dt;
        end
        b_op  = crossing ? t_cur_s : dt;
        j_mag = j_op[31] ? (~j_op + 32'd1) : j_op;
        a_mag = a_op[DT_W-1] ? 32'(-a_op) : 32'(a_op);
        b_mag = b_op[DT_W-1] ? 32'(-b_op) : 32'(b_op);
    end

    always_comb
    begin
        if (cmd.mul1)
        begin
            mul_x = j_mag;
            mul_y = a_mag;
        end
        else if (cmd.mul2)
        begin
            mul_x = p1_mag_reg[31:0];
            mul_y = b_mag_reg;
        end
        else
        begin
            mul_x = p1_mag_reg[63:32];
            mul_y = b_mag_reg;
        end
        mprod = {32'd0, mul_x} * {32'd0, mul_y};
        total = {1'b0, p2_mag_reg} + {1'b0, mprod[31:0], 32'd0};
        ovf   = (|mprod[63:32]) || total[64];
    end

    always_comb
    begin
        p1_s   = p1_neg_reg ? -$signed(p1_mag_reg) : $signed(p1_mag_reg);
        p2_s   = (p1_neg_reg ^ b_neg_reg) ? -$signed(p2_mag_reg) : $signed(p2_mag_reg);
        if (cmd.phase == PH_CRUISE)
        begin
            term = 64'sd0;
        end
        else if (use_j)
        begin
            term = p2_s >>> 1;
        end
        else
        begin
            term = p1_s;
        end
        sum    = {{(64-VEL_W){base_v_reg[VEL_W-1]}}, base_v_reg} + term;
        ba_sum = {{(64-VEL_W){base_a_reg[VEL_W-1]}}, base_a_reg} + p1_s;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            p1_mag_reg <= mprod;
            p1_neg_reg <= j_op[31] ^ a_op[DT_W-1];
            b_mag_reg  <= b_mag;
            b_neg_reg  <= b_op[DT_W-1];
        end
        if (cmd.mul2)
        begin
            p2_mag_reg <= mprod;
        end
        if (cmd.mul3)
        begin
            p2_mag_reg <= (ovf || (total[63:0] > PROD_LIM)) ? PROD_LIM : total[63:0];
        end
        if (cmd.load_out)
        begin
            result_reg.velocity     <= cur_v_reg;
            result_reg.phase        <= cmd.phase;
            result_reg.buffer_empty <= cmd.buffer_empty;
        end
        if (cmd.commit)
        begin
            pend_start_reg <= item.start_velocity;
            pend_end_reg   <= item.end_velocity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            seg_reg     <= '0;
            bnd_reg     <= '0;
            base_v_reg  <= '0;
            base_a_reg  <= '0;
            cur_v_reg   <= '0;
            end_v_reg   <= '0;
        end
        else
        begin
            if (cmd.follow_load)
            begin
                cur_v_reg <= sat_v({{(64-VEL_W){item.host_velocity[VEL_W-1]}},
                                    item.host_velocity});
            end
            if (cmd.init)
            begin
                base_v_reg  <= sat_v({{(64-VEL_W){pend_start_reg[VEL_W-1]}}, pend_start_reg});
                end_v_reg   <= sat_v({{(64-VEL_W){pend_end_reg[VEL_W-1]}}, pend_end_reg});
                base_a_reg  <= '0;
                elapsed_reg <= CNT_W'(1);
                seg_reg     <= '0;
                bnd_reg     <= CNT_W'(cfg.accel_jerk_ticks);
            end
            if (cmd.apply)
            begin
                if (!crossing)
                begin
                    cur_v_reg <= sat_v(sum);
                end
                else
                begin
                    if (cmd.phase != PH_DJERK_DN)
                    begin
                        seg_reg <= seg_reg + CNT_W'(t_cur);
                        bnd_reg <= bnd_reg + CNT_W'(t_nxt);
                    end
                    case (cmd.phase)
                        PH_JERK_UP:
                        begin
                            base_a_reg <= sat_v(p1_s);
                            base_v_reg <= sat_v(sum);
                        end
                        PH_ACCEL, PH_DECEL:
                        begin
                            base_v_reg <= sat_v(sum);
                        end
                        PH_JERK_DN:
                        begin
                            base_v_reg <= sat_v(sum);
                            base_a_reg <= '0;
                        end
                        PH_CRUISE:
                        begin
                            base_a_reg <= '0;
                        end
                        PH_DJERK_UP:
                        begin
                            base_a_reg <= sat_v(ba_sum);
                            base_v_reg <= sat_v(sum);
                        end
                        PH_DJERK_DN:
                        begin
                            cur_v_reg <= end_v_reg;
                        end
                        default:
                        begin
                            cur_v_reg <= cur_v_reg;
                        end
                    endcase
                end
            end
            if (cmd.inc_elapsed)
            begin
                elapsed_reg <= elapsed_reg + CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/s_curve_velocity_profiler_unit.sv
// ----------------------------------------------------------------------------
// S-curve velocity profiler
// Seven-phase jerk-limited velocity generator with a one-entry staging buffer.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  item      item_valid, item_ready, item (item_t)     in
//  result    result_valid, result_ready, result        out
//  config    psel, penable, pwrite, paddr, pwdata,     in / out
//            prdata, pready
//
//  Lock, commit and a tick that runs no phase pass from idle straight to done.
//  A running tick passes each phase it visits through the shared 32x32
//  multiplier three times, then applies.
//  Reset clears control, counter, velocity and config state, not the result.
//  A stalled result holds the block after the result register is full.
// ----------------------------------------------------------------------------
module s_curve_velocity_profiler_unit
    import svp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    svp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    svp_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("Input accepted again while an op is still in progress.");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("Result appeared without an op in progress.");

endmodule
